FILE: hw/rtl/smt_pkg.sv
// Package for the SST manifest table: sizes, codes, entry and probe types.
// Used by smt_cell and sst_manifest_table.
package smt_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);

  localparam logic [2:0] MODE_PUBLISH = 3'd0;
  localparam logic [2:0] MODE_COMMIT  = 3'd1;
  localparam logic [2:0] MODE_REVOKE  = 3'd2;
  localparam logic [2:0] MODE_ABORT   = 3'd3;
  localparam logic [2:0] MODE_LOOKUP  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [2:0] REG_META  = 3'd0;
  localparam logic [2:0] REG_ABI   = 3'd1;
  localparam logic [2:0] REG_LEVEL = 3'd2;
  localparam logic [2:0] REG_CHUNK = 3'd3;
  localparam logic [2:0] REG_FSIZE = 3'd4;
  localparam logic [2:0] REG_CSIZE = 3'd5;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] epoch;
    logic [7:0]  level;
    logic [63:0] low_key;
    logic [63:0] high_key;
    logic [15:0] chunks;
    logic [31:0] length;
  } rec_t;

  // Probe travelling down the chain of cells.
  typedef struct packed {
    logic        hit;
    logic        hit_committed;
    logic [63:0] hit_epoch;
    logic        best_ok;
    rec_t        best;
    logic        free_seen;
  } probe_t;

endpackage

FILE: hw/rtl/sst_manifest_table.sv
// SST manifest table top level: config registers, sequencer, chain of cells.
// Sequencing: once start is accepted, a search pass runs through every cell, then an
// update pass, and done rises; busy holds until then, so items are taken one at a time.
// The probe advances one cell per cycle through the registered cell outputs.
// Synchronous active-high reset empties the table, zeroes the version and
// restores register defaults. The receiver cannot stall results.
module sst_manifest_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  mode,
  input  logic [63:0] sst_id,
  input  logic [63:0] epoch,
  input  logic [63:0] lookup_key,
  input  logic [63:0] min_key,
  input  logic [63:0] max_key,
  input  logic [7:0]  level,
  input  logic [15:0] meta_version,
  input  logic [15:0] abi_version_in,
  input  logic [15:0] chunk_cnt,
  input  logic [31:0] byte_len,
  input  logic [31:0] chunk_bytes,
  output logic        done,
  output logic [2:0]  status,
  output logic        found,
  output logic [63:0] hit_sst_id,
  output logic [63:0] hit_epoch,
  output logic [7:0]  hit_level,
  output logic [63:0] hit_min_key,
  output logic [63:0] hit_max_key,
  output logic [15:0] hit_chunk_cnt,
  output logic [31:0] hit_byte_len,
  output logic [31:0] version_now,
  output logic [4:0]  count_now
);
  import smt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [15:0] metadata_version;
  logic [15:0] abi_version;
  logic [7:0]  max_level;
  logic [15:0] max_chunks;
  logic [31:0] max_file_size;
  logic [31:0] required_chunk_size;

  logic [1:0]  state;
  logic [IdxW-1:0] pass_cnt;
  logic [2:0]  op;
  rec_t        req;
  logic [63:0] qkey;
  logic        desc_ok;
  logic [CntW-1:0] record_count;
  logic [31:0] table_version;

  probe_t chain [MaxEntries+1];
  logic [MaxEntries-1:0] cell_valid;
  probe_t res;
  logic [2:0]  st;
  logic        upd_write;
  logic        upd_commit;
  logic        upd_drop;
  logic        upd_any;
  logic        sweep;
  logic        accept;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign sweep = (state == S_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      metadata_version <= 16'd1;
      abi_version <= 16'd1;
      max_level <= 8'd7;
      max_chunks <= 16'd256;
      max_file_size <= 32'd67108864;
      required_chunk_size <= 32'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_META:  metadata_version <= cfg_data[15:0];
        REG_ABI:   abi_version <= cfg_data[15:0];
        REG_LEVEL: max_level <= cfg_data[7:0];
        REG_CHUNK: max_chunks <= cfg_data[15:0];
        REG_FSIZE: max_file_size <= cfg_data;
        REG_CSIZE: required_chunk_size <= cfg_data;
        default: ;
      endcase
    end
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    smt_cell u_cell (
      .clk(clk), .rst(rst), .op(op), .sweep(sweep),
      .do_write(upd_write), .do_commit(upd_commit), .do_drop(upd_drop),
      .wr_rec(req), .key(qkey), .qepoch(req.epoch),
      .probe_in(chain[g]), .probe_out(chain[g+1]), .valid_out(cell_valid[g])
    );
  end

  assign res = chain[MaxEntries];

  always_comb begin
    st = ST_INVALID;
    upd_write = 1'b0;
    upd_commit = 1'b0;
    upd_drop = 1'b0;
    case (op)
      MODE_PUBLISH: begin
        if (!desc_ok) st = ST_INVALID;
        else if (res.hit) st = ST_EXISTS;
        else if (record_count >= CntW'(MaxEntries)) st = ST_FULL;
        else begin
          st = ST_OK;
          upd_write = 1'b1;
        end
      end
      MODE_COMMIT: begin
        if (req.epoch == 64'd0) st = ST_INVALID;
        else if (!res.hit) st = ST_NOTFOUND;
        else if (res.hit_committed || res.hit_epoch != req.epoch) st = ST_INVALID;
        else begin
          st = ST_OK;
          upd_commit = 1'b1;
        end
      end
      MODE_REVOKE: begin
        if (!res.hit) st = ST_NOTFOUND;
        else if (!res.hit_committed) st = ST_INVALID;
        else begin
          st = ST_OK;
          upd_drop = 1'b1;
        end
      end
      MODE_ABORT: begin
        if (req.id == 64'd0) st = ST_INVALID;
        else if (!res.hit) st = ST_NOTFOUND;
        else begin
          st = ST_OK;
          upd_drop = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        if (req.epoch == 64'd0) st = ST_INVALID;
        else if (res.best_ok) st = ST_OK;
        else st = ST_NOTFOUND;
      end
      default: st = ST_INVALID;
    endcase
    upd_any = upd_write || upd_commit || upd_drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass_cnt <= '0;
      done <= 1'b0;
      record_count <= '0;
      table_version <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SEARCH;
            pass_cnt <= '0;
          end
        end
        S_SEARCH: begin
          if (pass_cnt == IdxW'(MaxEntries - 1)) state <= S_UPDATE;
          else pass_cnt <= pass_cnt + IdxW'(1);
        end
        S_UPDATE: begin
          state <= S_IDLE;
          done <= 1'b1;
          if (upd_any) table_version <= table_version + 32'd1;
          if (upd_write) record_count <= record_count + CntW'(1);
          else if (upd_drop) record_count <= record_count - CntW'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= mode;
      req.id <= sst_id;
      req.epoch <= epoch;
      req.level <= level;
      req.low_key <= min_key;
      req.high_key <= max_key;
      req.chunks <= chunk_cnt;
      req.length <= byte_len;
      qkey <= lookup_key;
      desc_ok <= (meta_version == metadata_version) && (abi_version_in == abi_version) &&
                 (level <= max_level) && (epoch != 64'd0) && (min_key <= max_key) &&
                 (sst_id != 64'd0) && (chunk_cnt != 16'd0) &&
                 (chunk_cnt <= max_chunks) && (byte_len != 32'd0) &&
                 (byte_len <= max_file_size) && (chunk_bytes == required_chunk_size);
    end
  end

  always_ff @(posedge clk) begin
    if (sweep) begin
      status <= st;
      found <= (op == MODE_LOOKUP) && (st == ST_OK);
      if ((op == MODE_LOOKUP) && (st == ST_OK)) begin
        hit_sst_id <= res.best.id;
        hit_epoch <= res.best.epoch;
        hit_level <= res.best.level;
        hit_min_key <= res.best.low_key;
        hit_max_key <= res.best.high_key;
        hit_chunk_cnt <= res.best.chunks;
        hit_byte_len <= res.best.length;
      end else begin
        hit_sst_id <= '0;
        hit_epoch <= '0;
        hit_level <= '0;
        hit_min_key <= '0;
        hit_max_key <= '0;
        hit_chunk_cnt <= '0;
        hit_byte_len <= '0;
      end
    end
  end

  assign version_now = table_version;
  assign count_now = 5'(record_count);

`ifndef SYNTHESIS
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(record_count))
    else $error("record count disagrees with valid cells");
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_UPDATE)
    else $error("done without update pass");
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    sweep |-> $onehot0({upd_write, upd_commit, upd_drop}))
    else $error("multiple updates in one item");
`endif
endmodule

FILE: hw/rtl/smt_cell.sv
// One table slot: holds a record and folds it into the probe passing by.
// Depends on smt_pkg.
module smt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic [2:0]    op,
  input  logic          sweep,
  input  logic          do_write,
  input  logic          do_commit,
  input  logic          do_drop,
  input  smt_pkg::rec_t wr_rec,
  input  logic [63:0]   key,
  input  logic [63:0]   qepoch,
  input  smt_pkg::probe_t probe_in,
  output smt_pkg::probe_t probe_out,
  output logic          valid_out
);
  import smt_pkg::*;

  logic valid;
  logic committed;
  rec_t rec;
  logic id_match;
  logic take_slot;
  logic cand;
  logic better;
  probe_t probe_next;

  assign valid_out = valid;
  assign id_match = valid && (rec.id == wr_rec.id);
  assign take_slot = do_write && !valid && !probe_in.free_seen;
  assign cand = valid && committed && (rec.epoch <= qepoch) &&
                (key >= rec.low_key) && (key <= rec.high_key);
  assign better = !probe_in.best_ok || (rec.epoch > probe_in.best.epoch) ||
                  ((rec.epoch == probe_in.best.epoch) &&
                   ((rec.level < probe_in.best.level) ||
                    ((rec.level == probe_in.best.level) &&
                     (rec.id > probe_in.best.id))));

  always_comb begin
    probe_next = probe_in;
    probe_next.free_seen = probe_in.free_seen || !valid;
    if (id_match) begin
      probe_next.hit = 1'b1;
      probe_next.hit_committed = committed;
      probe_next.hit_epoch = rec.epoch;
    end
    if (op == MODE_LOOKUP && cand && better) begin
      probe_next.best_ok = 1'b1;
      probe_next.best = rec;
    end
  end

  // advance the probe one cell per cycle
  always_ff @(posedge clk) begin
    probe_out <= probe_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      committed <= 1'b0;
    end else if (sweep) begin
      if (take_slot) begin
        valid <= 1'b1;
        committed <= 1'b0;
      end else if (do_commit && id_match) begin
        committed <= 1'b1;
      end else if (do_drop && id_match) begin
        valid <= 1'b0;
        committed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep && take_slot) begin
      rec <= wr_rec;
    end
  end
endmodule

FILE: tb/sst_manifest_table_tb.sv
// Self-checking testbench for sst_manifest_table: directed and random publish,
// commit, revoke, abort and lookup transactions checked against a local table model.
// Depends on smt_pkg and the sst_manifest_table RTL.
module sst_manifest_table_tb;
  import smt_pkg::*;

  localparam int StallLimit = 5000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] id;
    logic [63:0] ep;
    logic [63:0] key;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  lvl;
    logic [15:0] mver;
    logic [15:0] aver;
    logic [15:0] chunks;
    logic [31:0] len;
    logic [31:0] csize;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [63:0] id;
    logic [63:0] ep;
    logic [7:0]  lvl;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] chunks;
    logic [31:0] len;
    logic [31:0] version;
    logic [4:0]  count;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic [2:0]  mode = '0;
  logic [63:0] sst_id = '0, epoch = '0, lookup_key = '0, min_key = '0, max_key = '0;
  logic [7:0]  level = '0;
  logic [15:0] meta_version = '0, abi_version_in = '0, chunk_cnt = '0;
  logic [31:0] byte_len = '0, chunk_bytes = '0;
  logic        done;
  logic [2:0]  status;
  logic        found;
  logic [63:0] hit_sst_id, hit_epoch, hit_min_key, hit_max_key;
  logic [7:0]  hit_level;
  logic [15:0] hit_chunk_cnt;
  logic [31:0] hit_byte_len, version_now;
  logic [4:0]  count_now;

  sst_manifest_table u_dut (.*);

  always #5 clk = ~clk;

  // table model
  logic [15:0] req_meta, req_abi, lim_chunks;
  logic [7:0]  lim_level;
  logic [31:0] lim_fsize, req_csize;
  logic        ent_valid [MaxEntries];
  logic        ent_comm  [MaxEntries];
  rec_t        ent       [MaxEntries];
  logic [4:0]  rec_count;
  logic [31:0] tbl_version;

  answer_t pending_answers[$];
  int      mismatches = 0;
  int      stall_cycles = 0;
  bit      idle_on = 1'b1;

  function automatic int slot_of(logic [63:0] id);
    for (int i = 0; i < MaxEntries; i++)
      if (ent_valid[i] && ent[i].id == id) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int s);
    ent_valid[s] = 1'b0;
    ent_comm[s] = 1'b0;
    rec_count--;
    tbl_version++;
  endfunction

  function automatic answer_t apply_cmd(cmd_t c);
    answer_t a;
    int s;
    int best;
    bit ok;
    a = '0;
    a.status = ST_INVALID;
    best = -1;
    case (c.mode)
      MODE_PUBLISH: begin
        ok = c.mver == req_meta && c.aver == req_abi && c.lvl <= lim_level &&
             c.ep != 0 && c.lo <= c.hi && c.id != 0 && c.chunks != 0 &&
             c.chunks <= lim_chunks && c.len != 0 && c.len <= lim_fsize &&
             c.csize == req_csize;
        if (!ok) a.status = ST_INVALID;
        else if (slot_of(c.id) >= 0) a.status = ST_EXISTS;
        else if (rec_count >= MaxEntries) a.status = ST_FULL;
        else begin
          s = 0;
          while (ent_valid[s]) s++;
          ent_valid[s] = 1'b1;
          ent_comm[s] = 1'b0;
          ent[s] = '{c.id, c.ep, c.lvl, c.lo, c.hi, c.chunks, c.len};
          rec_count++;
          tbl_version++;
          a.status = ST_OK;
        end
      end
      MODE_COMMIT: begin
        s = slot_of(c.id);
        if (c.ep == 0) a.status = ST_INVALID;
        else if (s < 0) a.status = ST_NOTFOUND;
        else if (ent_comm[s] || ent[s].epoch != c.ep) a.status = ST_INVALID;
        else begin
          ent_comm[s] = 1'b1;
          tbl_version++;
          a.status = ST_OK;
        end
      end
      MODE_REVOKE: begin
        s = slot_of(c.id);
        if (s < 0) a.status = ST_NOTFOUND;
        else if (!ent_comm[s]) a.status = ST_INVALID;
        else begin
          drop_entry(s);
          a.status = ST_OK;
        end
      end
      MODE_ABORT: begin
        s = slot_of(c.id);
        if (c.id == 0) a.status = ST_INVALID;
        else if (s < 0) a.status = ST_NOTFOUND;
        else begin
          drop_entry(s);
          a.status = ST_OK;
        end
      end
      MODE_LOOKUP: begin
        if (c.ep == 0) a.status = ST_INVALID;
        else begin
          for (int i = 0; i < MaxEntries; i++) begin
            if (!ent_valid[i] || !ent_comm[i] || ent[i].epoch > c.ep ||
                c.key < ent[i].low_key || c.key > ent[i].high_key) continue;
            if (best < 0 || ent[i].epoch > ent[best].epoch ||
                (ent[i].epoch == ent[best].epoch &&
                 (ent[i].level < ent[best].level ||
                  (ent[i].level == ent[best].level && ent[i].id > ent[best].id))))
              best = i;
          end
          a.status = best >= 0 ? ST_OK : ST_NOTFOUND;
        end
      end
      default: a.status = ST_INVALID;
    endcase
    if (best >= 0) begin
      a.found = 1'b1;
      a.id = ent[best].id;
      a.ep = ent[best].epoch;
      a.lvl = ent[best].level;
      a.lo = ent[best].low_key;
      a.hi = ent[best].high_key;
      a.chunks = ent[best].chunks;
      a.len = ent[best].length;
    end
    a.version = tbl_version;
    a.count = rec_count;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && done) begin
      got = '{status, found, hit_sst_id, hit_epoch, hit_level, hit_min_key, hit_max_key,
              hit_chunk_cnt, hit_byte_len, version_now, count_now};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) stall_cycles <= 0;
    else if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  task automatic send_cmd(cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    mode <= c.mode;
    sst_id <= c.id;
    epoch <= c.ep;
    lookup_key <= c.key;
    min_key <= c.lo;
    max_key <= c.hi;
    level <= c.lvl;
    meta_version <= c.mver;
    abi_version_in <= c.aver;
    chunk_cnt <= c.chunks;
    byte_len <= c.len;
    chunk_bytes <= c.csize;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_answers.push_back(apply_cmd(c));
  endtask

  task automatic drain();
    start <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_META:  req_meta = data[15:0];
      REG_ABI:   req_abi = data[15:0];
      REG_LEVEL: lim_level = data[7:0];
      REG_CHUNK: lim_chunks = data[15:0];
      REG_FSIZE: lim_fsize = data;
      REG_CSIZE: req_csize = data;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [15:0] m, logic [15:0] a, logic [7:0] l,
                            logic [15:0] ch, logic [31:0] fs, logic [31:0] cs);
    drain();
    write_reg(REG_META, {16'h0, m});
    write_reg(REG_ABI, {16'h0, a});
    write_reg(REG_LEVEL, {24'h0, l});
    write_reg(REG_CHUNK, {16'h0, ch});
    write_reg(REG_FSIZE, fs);
    write_reg(REG_CSIZE, cs);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cmd_t good_publish(logic [63:0] id, logic [63:0] ep,
                                        logic [63:0] lo, logic [63:0] hi);
    cmd_t c;
    c = '0;
    c.mode = MODE_PUBLISH;
    c.id = id;
    c.ep = ep;
    c.lo = lo;
    c.hi = hi;
    c.key = rand64();
    c.lvl = 8'($urandom_range(0, lim_level));
    c.mver = req_meta;
    c.aver = req_abi;
    c.chunks = 16'($urandom_range(1, lim_chunks));
    c.len = lim_fsize <= 1 ? 32'd1 : ($urandom % lim_fsize) + 32'd1;
    c.csize = req_csize;
    return c;
  endfunction

  function automatic cmd_t simple_cmd(logic [2:0] m, logic [63:0] id, logic [63:0] ep,
                                      logic [63:0] key);
    cmd_t c;
    c = '0;
    c.mode = m;
    c.id = id;
    c.ep = ep;
    c.key = key;
    return c;
  endfunction

  task automatic test_publish_checks();
    cmd_t c;
    send_cmd(good_publish(64'd1, 64'd5, 64'd10, 64'd20));
    send_cmd(good_publish(64'd1, 64'd5, 64'd10, 64'd20));
    for (int f = 0; f < 11; f++) begin
      c = good_publish(64'd9, 64'd3, 64'd0, 64'd100);
      case (f)
        0: c.mver = req_meta + 16'd1;
        1: c.aver = req_abi + 16'd1;
        2: c.lvl = lim_level + 8'd1;
        3: c.ep = '0;
        4: begin c.lo = 64'd200; c.hi = 64'd199; end
        5: c.id = '0;
        6: c.chunks = '0;
        7: c.chunks = lim_chunks + 16'd1;
        8: c.len = '0;
        9: c.len = lim_fsize + 32'd1;
        default: c.csize = req_csize - 32'd1;
      endcase
      send_cmd(c);
    end
  endtask

  task automatic test_commit_lookup();
    send_cmd(simple_cmd(MODE_LOOKUP, '0, 64'd5, 64'd15));
    send_cmd(simple_cmd(MODE_COMMIT, 64'd1, 64'd0, '0));
    send_cmd(simple_cmd(MODE_COMMIT, 64'd77, 64'd5, '0));
    send_cmd(simple_cmd(MODE_COMMIT, 64'd1, 64'd4, '0));
    send_cmd(simple_cmd(MODE_COMMIT, 64'd1, 64'd5, '0));
    send_cmd(simple_cmd(MODE_COMMIT, 64'd1, 64'd5, '0));
    send_cmd(simple_cmd(MODE_LOOKUP, '0, '1, 64'd20));
    send_cmd(simple_cmd(MODE_LOOKUP, '0, 64'd4, 64'd15));
    send_cmd(simple_cmd(MODE_LOOKUP, '0, 64'd0, 64'd15));
  endtask

  task automatic test_remove_and_bad_modes();
    send_cmd(good_publish(64'd2, 64'd7, '0, '1));
    send_cmd(simple_cmd(MODE_REVOKE, 64'd2, '0, '0));
    send_cmd(simple_cmd(MODE_REVOKE, 64'd55, '0, '0));
    send_cmd(simple_cmd(MODE_ABORT, 64'd0, '0, '0));
    send_cmd(simple_cmd(MODE_ABORT, 64'd55, '0, '0));
    send_cmd(simple_cmd(MODE_ABORT, 64'd2, '0, '0));
    send_cmd(simple_cmd(MODE_REVOKE, 64'd1, '0, '0));
    for (int m = 5; m < 8; m++) send_cmd(simple_cmd(3'(m), 64'd1, 64'd5, '0));
  endtask

  // mostly well-formed traffic over a small id pool so the table fills and empties
  task automatic test_random_traffic(int n);
    cmd_t c;
    int s;
    int pick;
    logic [63:0] lo;
    logic [63:0] hi;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      lo = 64'($urandom_range(0, 60));
      hi = lo + 64'($urandom_range(0, 60));
      if ($urandom_range(0, 9) == 0) begin lo = '0; hi = '1; end
      c = good_publish(64'($urandom_range(1, 22)), 64'($urandom_range(1, 6)), lo, hi);
      if ($urandom_range(0, 15) == 0) c.id = rand64();
      if ($urandom_range(0, 15) == 0) c.ep = rand64();
      c.key = 64'($urandom_range(0, 130));
      if ($urandom_range(0, 7) == 0) c.key = rand64();
      s = slot_of(c.id);
      if (pick < 35) begin
        if ($urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 5))
            0: c.mver = 16'($urandom);
            1: c.aver = 16'($urandom);
            2: c.lvl = 8'($urandom);
            3: c.chunks = 16'($urandom);
            4: c.len = $urandom;
            default: c.csize = $urandom;
          endcase
          if ($urandom_range(0, 3) == 0) {c.lo, c.hi} = {rand64(), rand64()};
        end
      end else if (pick < 60) begin
        c.mode = MODE_COMMIT;
        if (s >= 0 && $urandom_range(0, 3) != 0) c.ep = ent[s].epoch;
        if ($urandom_range(0, 19) == 0) c.ep = '0;
      end else if (pick < 85) begin
        c.mode = MODE_LOOKUP;
        c.ep = 64'($urandom_range(0, 8));
        if ($urandom_range(0, 9) == 0) c.ep = '1;
      end else if (pick < 92) c.mode = MODE_REVOKE;
      else if (pick < 97) begin
        c.mode = MODE_ABORT;
        if ($urandom_range(0, 9) == 0) c.id = '0;
      end else c.mode = 3'($urandom_range(5, 7));
      send_cmd(c);
    end
  endtask

  initial begin
    req_meta = 16'd1;
    req_abi = 16'd1;
    lim_level = 8'd7;
    lim_chunks = 16'd256;
    lim_fsize = 32'd67108864;
    req_csize = 32'd4096;
    for (int i = 0; i < MaxEntries; i++) begin
      ent_valid[i] = 1'b0;
      ent_comm[i] = 1'b0;
      ent[i] = '0;
    end
    rec_count = '0;
    tbl_version = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_publish_checks();
    test_commit_lookup();
    test_remove_and_bad_modes();
    test_random_traffic(220);
    set_limits(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random_traffic(220);
    set_limits(16'h0000, 16'h0000, 8'h00, 16'h0001, 32'h1, 32'h1);
    test_random_traffic(200);
    set_limits(16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)),
               16'($urandom_range(1, 65535)), $urandom | 32'h1, $urandom | 32'h1);
    idle_on = 1'b0;
    test_random_traffic(220);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
